FILE: design/sac_pkg.sv
package sac_pkg;
   localparam int MaxSetBits = 6;
   localparam int MaxWays    = 8;
   localparam int AddrBits   = 48;
   localparam int NumSets    = 1 << MaxSetBits;
   localparam int WayBits    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
   localparam int RankBits   = WayBits;
   // one row per set: valid, tag and rank for every way
   localparam int LineBits   = 1 + AddrBits + RankBits;
   localparam int RowBits    = LineBits * MaxWays;
   localparam int CntBits    = 32;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_IFETCH = 2'd3;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   localparam logic [1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS        = 2'd2;

   typedef struct packed {
      logic [1:0]          operation;
      logic [AddrBits-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]         outcome;
      logic [2:0]         way_used;
      logic               last;
      logic [CntBits-1:0] hit_total;
      logic [CntBits-1:0] miss_total;
      logic [CntBits-1:0] eviction_total;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [AddrBits-1:0] tag;
      logic [RankBits-1:0] rank;
   } line_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [1:0]          outcome;
      logic [WayBits-1:0]  way;
   } lookup_type;
endpackage

FILE: design/set_assoc_cache_lru_sim_top.sv
// tag-only set-associative cache model with true lru replacement
// request channel: start with req_data (operation, address); accepted when
// start is high and busy is low. instruction fetches are dropped at once.
// result channel: rsp_valid strobes for one cycle with rsp_data; the
// receiver cannot stall, so results are never held.
// csr channel: csr_valid/csr_ready with csr_index and csr_data; 0 set_bits,
// 1 offset_bits, 2 ways_in_use. writes are taken in any state.
// sequence: a load or store gives one result, registered after the set
// row read and then the compare and row write-back. a modify runs the
// row read and write-back twice and gives a result after each pass.
// every request ends in the idle state, where the next one is accepted;
// an instruction fetch is dropped in the idle state without leaving it.
// reset: counters and config return to reset values and a clearing pass
// writes every set row invalid, during which busy stays high.
module set_assoc_cache_lru_sim_top import sac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   localparam int SetAw = MaxSetBits > 0 ? MaxSetBits : 1;

   state_type state_ff, state_in;
   logic [2:0] set_bits_ff;
   logic [4:0] offset_bits_ff;
   logic [3:0] ways_ff;
   logic [1:0]          op_ff, op_in;
   logic [AddrBits-1:0] tag_ff, tag_in;
   logic [SetAw-1:0]    set_ff, set_in;
   logic                second_ff, second_in;
   logic [SetAw-1:0]    clr_ff, clr_in;
   logic [CntBits-1:0]  hits_ff, hits_in, miss_ff, miss_in, evict_ff, evict_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic               wr_en;
   logic [SetAw-1:0]   wr_addr, rd_addr;
   logic [RowBits-1:0] wr_data, rd_data, row_new;
   lookup_type         lk;
   logic [2:0]         sb;
   logic [3:0]         ways;
   logic [AddrBits-1:0] shifted;
   logic [AddrBits-1:0] set_mask;

   sac_ram #(.Width(RowBits), .Depth(NumSets)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   sac_lookup u_lookup (
      .row(rd_data), .tag(tag_ff), .ways(ways), .res(lk), .row_new(row_new)
   );

   assign csr_ready = 1'b1;
   assign sb   = (set_bits_ff > 3'(MaxSetBits)) ? 3'(MaxSetBits) : set_bits_ff;
   assign ways = (ways_ff == 4'd0) ? 4'd1 :
                 (ways_ff > 4'(MaxWays)) ? 4'(MaxWays) : ways_ff;
   assign shifted  = req_data.address >> offset_bits_ff;
   assign set_mask = (AddrBits'(1) << sb) - AddrBits'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= 3'd4;
         offset_bits_ff <= 5'd4;
         ways_ff        <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_ff    <= csr_data[2:0];
            CSR_OFFSET_BITS: offset_bits_ff <= csr_data[4:0];
            CSR_WAYS:        ways_ff        <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
      op_ff  <= op_in;
      tag_ff <= tag_in;
      set_ff <= set_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      tag_in = tag_ff;
      set_in = set_ff;
      second_in = second_ff;
      hits_in = hits_ff;
      miss_in = miss_ff;
      evict_in = evict_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = set_ff;
      wr_data = row_new;
      rd_addr = set_ff;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SetAw'(NumSets - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start && req_data.operation != OP_IFETCH) begin
               op_in = req_data.operation;
               set_in = SetAw'(shifted & set_mask);
               tag_in = shifted >> sb;
               second_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            wr_en = 1'b1;
            if (lk.outcome == OUT_HIT) begin
               if (hits_ff != '1) hits_in = hits_ff + 1'b1;
            end else begin
               if (miss_ff != '1) miss_in = miss_ff + 1'b1;
               if (lk.outcome == OUT_EVICT && evict_ff != '1) evict_in = evict_ff + 1'b1;
            end
            rsp_valid_in = 1'b1;
            rsp_in.outcome = lk.outcome;
            rsp_in.way_used = 3'(lk.way);
            rsp_in.last = !(op_ff == OP_MODIFY && !second_ff);
            rsp_in.hit_total = hits_in;
            rsp_in.miss_total = miss_in;
            rsp_in.eviction_total = evict_in;
            if (op_ff == OP_MODIFY && !second_ff) begin
               second_in = 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_second_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last && $past(rsp_valid, 2) && !$past(rsp_data.last, 2)
      |-> rsp_data.outcome == OUT_HIT)
      else $error("second modify access missed");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> busy)
      else $error("update state not busy");
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.miss_total >= rsp_data.eviction_total)
      else $error("evictions exceed misses");
`endif
endmodule

FILE: design/sac_ram.sv
module sac_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/sac_lookup.sv
module sac_lookup import sac_pkg::*; (
   input  logic [RowBits-1:0]  row,
   input  logic [AddrBits-1:0] tag,
   input  logic [3:0]          ways,
   output lookup_type          res,
   output logic [RowBits-1:0]  row_new
);
   line_type lines [MaxWays];
   line_type upd [MaxWays];
   logic [MaxWays-1:0] hit_vec;
   logic [MaxWays-1:0] empty_vec;
   logic [WayBits-1:0] sel;
   logic [RankBits:0]  r_old;
   logic               found;
   logic               have_empty;
   logic [RankBits-1:0] oldest;

   always_comb begin
      for (int i = 0; i < MaxWays; i++) begin
         lines[i] = row[i*LineBits +: LineBits];
         hit_vec[i]   = (i < ways) && lines[i].valid && (lines[i].tag == tag);
         empty_vec[i] = (i < ways) && !lines[i].valid;
      end
      found = 1'b0;
      have_empty = 1'b0;
      sel = '0;
      oldest = lines[0].rank;
      for (int i = MaxWays - 1; i >= 0; i--) begin
         if (empty_vec[i]) begin
            have_empty = 1'b1;
            sel = WayBits'(i);
         end
      end
      for (int i = MaxWays - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            found = 1'b1;
         end
      end
      if (found) begin
         for (int i = MaxWays - 1; i >= 0; i--) begin
            if (hit_vec[i]) sel = WayBits'(i);
         end
         res.outcome = OUT_HIT;
         r_old = {1'b0, lines[sel].rank};
      end else if (have_empty) begin
         res.outcome = OUT_FILL;
         r_old = {1'b1, {RankBits{1'b0}}};
      end else begin
         // first way with the largest rank
         sel = '0;
         for (int i = 1; i < MaxWays; i++) begin
            if ((i < ways) && (lines[i].rank > oldest)) begin
               oldest = lines[i].rank;
               sel = WayBits'(i);
            end
         end
         res.outcome = OUT_EVICT;
         r_old = {1'b0, oldest};
      end
      res.way = sel;
      for (int i = 0; i < MaxWays; i++) begin
         upd[i] = lines[i];
         if (WayBits'(i) == sel) begin
            upd[i].valid = 1'b1;
            upd[i].tag   = tag;
            upd[i].rank  = '0;
         end else if (lines[i].valid && ({1'b0, lines[i].rank} < r_old)) begin
            upd[i].rank = lines[i].rank + 1'b1;
         end
         row_new[i*LineBits +: LineBits] = upd[i];
      end
   end
endmodule

FILE: tb/tb_cache_checker.sv
`timescale 1ns / 100ps

module tb_cache_checker import sac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending_count
);
   localparam int NumLines = NumSets * MaxWays;

   logic [2:0]          cfg_set_bits;
   logic [4:0]          cfg_offset_bits;
   logic [3:0]          cfg_ways;
   logic                line_valid [NumLines];
   logic [AddrBits-1:0] line_tag   [NumLines];
   logic [RankBits-1:0] line_rank  [NumLines];
   logic [31:0]         hit_cnt, miss_cnt, evict_cnt;
   rsp_type             expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 32'd1;
   endfunction

   // promote way w to most recent; lines newer than old_rank age by one
   function automatic void promote(int base, int w, int old_rank);
      for (int i = 0; i < MaxWays; i++)
         if (i != w && line_valid[base+i] && int'(line_rank[base+i]) < old_rank)
            line_rank[base+i] = line_rank[base+i] + 1'b1;
      line_rank[base+w] = '0;
   endfunction

   function automatic rsp_type cache_access(logic [AddrBits-1:0] addr, logic last_flag);
      int      sb, ways, set_idx, base, victim, oldest, sh;
      logic [63:0] tag;
      rsp_type r;
      sb   = (cfg_set_bits > MaxSetBits) ? MaxSetBits : cfg_set_bits;
      ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MaxWays) ? MaxWays : cfg_ways);
      set_idx = int'((64'(addr) >> cfg_offset_bits) & ((64'd1 << sb) - 1));
      sh   = cfg_offset_bits + sb;
      tag  = 64'(addr) >> sh;
      base = set_idx * MaxWays;
      r = '0;
      r.last = last_flag;
      for (int i = 0; i < ways; i++)
         if (line_valid[base+i] && 64'(line_tag[base+i]) == tag) begin
            promote(base, i, line_rank[base+i]);
            hit_cnt = sat_inc(hit_cnt);
            r.outcome = OUT_HIT;
            r.way_used = 3'(i);
            r.hit_total = hit_cnt; r.miss_total = miss_cnt; r.eviction_total = evict_cnt;
            return r;
         end
      for (int i = 0; i < ways; i++)
         if (!line_valid[base+i]) begin
            promote(base, i, NumLines);
            line_valid[base+i] = 1'b1;
            line_tag[base+i] = AddrBits'(tag);
            miss_cnt = sat_inc(miss_cnt);
            r.outcome = OUT_FILL;
            r.way_used = 3'(i);
            r.hit_total = hit_cnt; r.miss_total = miss_cnt; r.eviction_total = evict_cnt;
            return r;
         end
      victim = 0;
      oldest = line_rank[base];
      for (int i = 1; i < ways; i++)
         if (int'(line_rank[base+i]) > oldest) begin
            oldest = line_rank[base+i];
            victim = i;
         end
      promote(base, victim, oldest);
      line_tag[base+victim] = AddrBits'(tag);
      miss_cnt  = sat_inc(miss_cnt);
      evict_cnt = sat_inc(evict_cnt);
      r.outcome = OUT_EVICT;
      r.way_used = 3'(victim);
      r.hit_total = hit_cnt; r.miss_total = miss_cnt; r.eviction_total = evict_cnt;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_set_bits = 3'd4;
         cfg_offset_bits = 5'd4;
         cfg_ways = 4'd1;
         for (int i = 0; i < NumLines; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i] = '0;
            line_rank[i] = '0;
         end
         hit_cnt = '0; miss_cnt = '0; evict_cnt = '0;
         fail_count = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (e.outcome != rsp_data.outcome || e.way_used != rsp_data.way_used
                   || e.last != rsp_data.last || e.hit_total != rsp_data.hit_total
                   || e.miss_total != rsp_data.miss_total
                   || e.eviction_total != rsp_data.eviction_total) begin
                  $display("%0t: result mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            case (csr_index)
               CSR_SET_BITS:    cfg_set_bits = csr_data[2:0];
               CSR_OFFSET_BITS: cfg_offset_bits = csr_data[4:0];
               CSR_WAYS:        cfg_ways = csr_data[3:0];
               default: ;
            endcase
         if (start && !busy) begin
            if (req_data.operation == OP_MODIFY) begin
               expected_rsp.push_back(cache_access(req_data.address, 1'b0));
               expected_rsp.push_back(cache_access(req_data.address, 1'b1));
            end else if (req_data.operation != OP_IFETCH) begin
               expected_rsp.push_back(cache_access(req_data.address, 1'b1));
            end
         end
      end
   end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb import sac_pkg::*; ();
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   int          idle_pct = 0;
   logic [47:0] addr_pool [16];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   set_assoc_cache_lru_sim_top i_dut (.*);

   tb_cache_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("set_assoc_cache_lru_sim_top test failed");
         $finish;
      end
   end

   // start stays high from one request to the next unless the sender idles or a csr write comes between
   task automatic send_request(logic [1:0] op, logic [47:0] addr);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_data <= {op, addr};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_and_write(logic [1:0] idx, logic [31:0] value);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int sb, int ob, int w);
      drain_and_write(CSR_SET_BITS, sb);
      drain_and_write(CSR_OFFSET_BITS, ob);
      drain_and_write(CSR_WAYS, w);
   endtask

   // mostly addresses from a small pool so sets fill, hit and evict
   function automatic logic [47:0] pick_address();
      if ($urandom_range(9) < 8)
         return addr_pool[$urandom_range(15)];
      return 48'({$urandom(), $urandom()});
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < 16; i++)
         addr_pool[i] = 48'({$urandom(), $urandom()});
      for (int i = 0; i < count; i++)
         send_request(2'($urandom_range(3)), pick_address());
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      // directed: each op, address extremes, fill, hit, eviction
      send_request(OP_LOAD, 48'h0);
      send_request(OP_LOAD, 48'h0);
      send_request(OP_STORE, 48'hffff_ffff_ffff);
      send_request(OP_MODIFY, 48'h0000_0000_0100);
      send_request(OP_IFETCH, 48'haaaa_5555_aaaa);
      send_request(OP_MODIFY, 48'h0);
      configure(2, 3, 8);
      for (int i = 0; i < 10; i++)
         send_request(OP_LOAD, 48'(i) << 5);
      send_request(OP_STORE, 48'h0);
      send_request(OP_LOAD, 48'h5555_5555_5555);
      configure(7, 31, 0);
      send_request(OP_LOAD, 48'hffff_ffff_ffff);
      send_request(OP_MODIFY, 48'h8000_0000_0000);
      configure(0, 0, 15);
      random_phase(150);
      configure(1, 2, 2);
      idle_pct = 64;
      random_phase(150);
      configure(6, 16, 8);
      idle_pct = 12;
      random_phase(150);
      configure(3, 8, 4);
      idle_pct = 0;
      random_phase(150);
      configure(4, 4, 1);
      idle_pct = 64;
      random_phase(150);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("set_assoc_cache_lru_sim_top test passed");
      else
         $display("set_assoc_cache_lru_sim_top test failed");
      $finish;
   end
endmodule
